// ===== hw/rtl/vdd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vdd_pkg
// Shared widths, codes and defaults for the volume distance dilation block.
// ----------------------------------------------------------------------------
package vdd_pkg;

    localparam int MAX_EDGE_DEF   = 64;
    localparam int VALUE_BITS_DEF = 16;

    localparam int CFG_W  = 7;
    localparam int IDX_W  = 2;
    localparam int OP_W   = 2;
    localparam int ADDR_W = 18;
    localparam int PORT_W = 16;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    localparam logic [IDX_W-1:0] REG_ROW    = 2'd0;
    localparam logic [IDX_W-1:0] REG_COLUMN = 2'd1;
    localparam logic [IDX_W-1:0] REG_SLICE  = 2'd2;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_RUN   = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_RUN  = 1'b1;

endpackage
`default_nettype wire

// ===== hw/rtl/volume_distance_dilation.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// volume_distance_dilation
// Voxel volume store with in-place grayscale 6-neighbour dilation runs.
// ----------------------------------------------------------------------------
// Write items may come every cycle while the result channel is not stalled.
// A read item's result passes through the registered memory read and then
// the result register, and no item is accepted while a read is on its way.
// A run item first sweeps the volume in use for its largest value M, then
// makes up to M passes, the seven reads of a voxel and its neighbours
// sharing the single read port of the voxel memory; a run ends early once
// a pass changes nothing. When the passes made are odd in number, a copy
// sweep brings the volume in use back to the front memory. The run result
// is then offered through the result register once the output is free. The
// block takes no item after reset or after a configuration write while the
// volume size is recomputed.
module volume_distance_dilation
    import vdd_pkg::*;
#(
    parameter int MAX_EDGE   = MAX_EDGE_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [OP_W-1:0]   i_opcode,
    input  wire logic [ADDR_W-1:0] i_voxel_address,
    input  wire logic [PORT_W-1:0] i_voxel_value,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic                   o_result_kind,
    output logic      [PORT_W-1:0] o_read_value,
    output logic                   o_address_error,
    output logic      [PORT_W-1:0] o_passes_done
);

    localparam int EB    = $clog2(MAX_EDGE + 1);
    localparam int AB    = 3 * $clog2(MAX_EDGE);
    localparam int DEPTH = MAX_EDGE * MAX_EDGE * MAX_EDGE;
    localparam int TW    = 3 * EB;
    localparam int CMPW  = (TW > ADDR_W) ? TW : ADDR_W;
    localparam int VB    = VALUE_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MAX   = 3'd1;
    localparam logic [2:0] S_MAXW  = 3'd2;
    localparam logic [2:0] S_PASS  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;
    localparam logic [2:0] S_COPY  = 3'd5;
    localparam logic [2:0] S_COPYW = 3'd6;

    localparam logic [2:0] K_SELF  = 3'd0;
    localparam logic [2:0] K_XM    = 3'd1;
    localparam logic [2:0] K_XP    = 3'd2;
    localparam logic [2:0] K_YM    = 3'd3;
    localparam logic [2:0] K_YP    = 3'd4;
    localparam logic [2:0] K_ZM    = 3'd5;
    localparam logic [2:0] K_ZP    = 3'd6;
    localparam logic [2:0] K_WRITE = 3'd7;

    logic [CFG_W-1:0] r_cfg_row, r_cfg_col, r_cfg_slc;
    logic [1:0]       r_settle;
    logic [2*EB-1:0]  r_plane;
    logic [TW-1:0]    r_total;
    logic [2:0]       r_state;
    logic [AB-1:0]    r_p;
    logic [EB-1:0]    r_x, r_y, r_z;
    logic [2:0]       r_k;
    logic [VB-1:0]    r_t, r_m, r_best, r_self;
    logic             r_changed;
    logic             r_front;
    logic             r_rv;
    logic             r_rd_pend;
    logic             r_rd_err;

    logic [EB-1:0]    rs, cs, ds;
    logic [AB-1:0]    last_p, row_step, plane_step;
    logic             accept, in_range, out_free;
    logic [CMPW-1:0]  in_addr_ext;
    logic [AB-1:0]    in_mem_addr;
    logic [31:0]      in_val_ext, rd_ext, m_ext;
    logic [VB-1:0]    rd_data, n_best, n_m;
    logic [7:0]       v_ok;
    logic             n_changed, end_x, end_y, end_z;
    logic [VB:0]      t_next;
    logic [AB-1:0]    mem_rd_addr, mem_wr_addr;
    logic             mem_we, mem_wr_back;
    logic [VB-1:0]    mem_wr_data;

    function automatic logic [EB-1:0] clamp_edge(input logic [CFG_W-1:0] v);
        logic [EB-1:0] r;
        if (v == '0) begin
            r = EB'(1);
        end else if (32'(v) > MAX_EDGE) begin
            r = EB'(MAX_EDGE);
        end else begin
            r = EB'(v);
        end
        return r;
    endfunction

    assign rs = clamp_edge(r_cfg_row);
    assign cs = clamp_edge(r_cfg_col);
    assign ds = clamp_edge(r_cfg_slc);

    assign last_p     = AB'(r_total - TW'(1));
    assign row_step   = AB'(rs);
    assign plane_step = AB'(r_plane);

    assign out_free    = !o_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && (r_settle == 2'd0) && !r_rd_pend && out_free;
    assign accept      = i_in_valid && o_in_ready;
    assign in_addr_ext = CMPW'(i_voxel_address);
    assign in_range    = in_addr_ext < CMPW'(r_total);
    assign in_mem_addr = in_addr_ext[AB-1:0];
    assign in_val_ext  = 32'(i_voxel_value);

    assign end_x = (r_x == rs - EB'(1));
    assign end_y = (r_y == cs - EB'(1));
    assign end_z = (r_z == ds - EB'(1));

    // ok bit k belongs to the neighbour whose data arrives at step k
    assign v_ok = {!end_z, (r_z != '0), !end_y, (r_y != '0), !end_x, (r_x != '0), 2'b00};

    always_comb begin
        case (r_k)
            K_XM: n_best = rd_data;
            default: begin
                if (v_ok[r_k] && rd_data >= r_t && rd_data > r_best) begin
                    n_best = rd_data;
                end else begin
                    n_best = r_best;
                end
            end
        endcase
    end

    assign n_changed = r_changed || (n_best != r_self);
    assign t_next    = (VB+1)'(r_t) + (VB+1)'(1);
    assign n_m       = (r_rv && rd_data > r_m) ? rd_data : r_m;

    always_comb begin
        mem_rd_addr = in_mem_addr;
        if (r_state == S_MAX || r_state == S_COPY) begin
            mem_rd_addr = r_p;
        end else if (r_state == S_PASS) begin
            case (r_k)
                K_XM:    mem_rd_addr = r_p - AB'(1);
                K_XP:    mem_rd_addr = r_p + AB'(1);
                K_YM:    mem_rd_addr = r_p - row_step;
                K_YP:    mem_rd_addr = r_p + row_step;
                K_ZM:    mem_rd_addr = r_p - plane_step;
                K_ZP:    mem_rd_addr = r_p + plane_step;
                default: mem_rd_addr = r_p;
            endcase
        end
    end

    always_comb begin
        mem_we      = 1'b0;
        mem_wr_back = 1'b0;
        mem_wr_addr = in_mem_addr;
        mem_wr_data = in_val_ext[VB-1:0];
        if (accept && i_opcode == OP_WRITE && in_range) begin
            mem_we = 1'b1;
        end else if (r_state == S_PASS && r_k == K_WRITE) begin
            mem_we      = 1'b1;
            mem_wr_back = 1'b1;
            mem_wr_addr = r_p;
            mem_wr_data = n_best;
        end else if ((r_state == S_COPY && r_p != '0) || r_state == S_COPYW) begin
            // copy back: registered read data from the previous address goes to the other memory
            mem_we      = 1'b1;
            mem_wr_back = 1'b1;
            mem_wr_addr = r_p - AB'(1);
            mem_wr_data = rd_data;
        end
    end

    vdd_banks #(
        .AB    (AB),
        .DEPTH (DEPTH),
        .VB    (VB)
    ) u_banks (
        .i_clk     (i_clk),
        .i_rd_addr (mem_rd_addr),
        .i_front   (r_front),
        .i_we      (mem_we),
        .i_wr_back (mem_wr_back),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .o_rd_data (rd_data)
    );

    assign rd_ext = 32'(rd_data);
    assign m_ext  = 32'(r_m);

    // configuration and derived volume size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_row <= CFG_RESET;
            r_cfg_col <= CFG_RESET;
            r_cfg_slc <= CFG_RESET;
            r_settle  <= 2'd2;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_ROW:    r_cfg_row <= i_cfg_data;
                    REG_COLUMN: r_cfg_col <= i_cfg_data;
                    REG_SLICE:  r_cfg_slc <= i_cfg_data;
                    default:    ;
                endcase
                r_settle <= 2'd2;
            end else if (r_settle != 2'd0) begin
                r_settle <= r_settle - 2'd1;
            end
        end
        r_plane <= (2*EB)'(rs) * (2*EB)'(cs);
        r_total <= TW'(r_plane) * TW'(ds);
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_front   <= 1'b0;
            r_rv      <= 1'b0;
            r_m       <= '0;
            r_t       <= '0;
            r_k       <= K_SELF;
            r_changed <= 1'b0;
        end else begin
            r_rv <= (r_state == S_MAX);
            unique case (r_state)
                S_IDLE: begin
                    if (accept && i_opcode == OP_RUN) begin
                        r_state <= S_MAX;
                        r_p     <= '0;
                        r_m     <= '0;
                    end
                end
                S_MAX: begin
                    r_m <= n_m;
                    r_p <= r_p + AB'(1);
                    if (r_p == last_p) begin
                        r_state <= S_MAXW;
                    end
                end
                S_MAXW: begin
                    r_m       <= n_m;
                    r_p       <= '0;
                    r_x       <= '0;
                    r_y       <= '0;
                    r_z       <= '0;
                    r_k       <= K_SELF;
                    r_t       <= '0;
                    r_changed <= 1'b0;
                    r_state   <= (n_m == '0) ? S_DONE : S_PASS;
                end
                S_PASS: begin
                    r_best <= n_best;
                    if (r_k == K_XM) begin
                        r_self <= rd_data;
                    end
                    r_k <= r_k + 3'd1;
                    if (r_k == K_WRITE) begin
                        r_changed <= n_changed;
                        r_p       <= r_p + AB'(1);
                        r_x       <= r_x + EB'(1);
                        if (end_x) begin
                            r_x <= '0;
                            r_y <= r_y + EB'(1);
                            if (end_y) begin
                                r_y <= '0;
                                r_z <= r_z + EB'(1);
                                if (end_z) begin
                                    r_z       <= '0;
                                    r_p       <= '0;
                                    r_front   <= ~r_front;
                                    r_changed <= 1'b0;
                                    r_t       <= t_next[VB-1:0];
                                    if (!n_changed || t_next == (VB+1)'(r_m)) begin
                                        r_state <= r_front ? S_DONE : S_COPY;
                                    end
                                end
                            end
                        end
                    end
                end
                S_COPY: begin
                    r_p <= r_p + AB'(1);
                    if (r_p == last_p) begin
                        r_state <= S_COPYW;
                    end
                end
                S_COPYW: begin
                    r_front <= 1'b0;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend   <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_rd_pend <= accept && i_opcode == OP_READ;
            if (r_rd_pend) begin
                o_out_valid <= 1'b1;
            end else if (r_state == S_DONE && out_free) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
        r_rd_err <= !in_range;
        if (r_rd_pend) begin
            o_result_kind   <= KIND_READ;
            o_read_value    <= r_rd_err ? '0 : rd_ext[PORT_W-1:0];
            o_address_error <= r_rd_err;
            o_passes_done   <= '0;
        end else if (r_state == S_DONE && out_free) begin
            o_result_kind   <= KIND_RUN;
            o_read_value    <= '0;
            o_address_error <= 1'b0;
            o_passes_done   <= m_ext[PORT_W-1:0];
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/vdd_banks.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vdd_banks
// Front and back voxel memories, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module vdd_banks #(
    parameter int AB    = 18,
    parameter int DEPTH = 262144,
    parameter int VB    = 16
) (
    input  wire logic          i_clk,
    input  wire logic [AB-1:0] i_rd_addr,
    input  wire logic          i_front,
    input  wire logic          i_we,
    input  wire logic          i_wr_back,
    input  wire logic [AB-1:0] i_wr_addr,
    input  wire logic [VB-1:0] i_wr_data,
    output logic      [VB-1:0] o_rd_data
);

    logic [VB-1:0] mem0 [0:DEPTH-1];
    logic [VB-1:0] mem1 [0:DEPTH-1];
    logic [VB-1:0] r_rd0;
    logic [VB-1:0] r_rd1;
    logic          r_sel;
    logic          wr_bank;

    assign wr_bank = i_wr_back ? ~i_front : i_front;

    always_ff @(posedge i_clk) begin
        if (i_we && !wr_bank) begin
            mem0[i_wr_addr] <= i_wr_data;
        end
        r_rd0 <= mem0[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we && wr_bank) begin
            mem1[i_wr_addr] <= i_wr_data;
        end
        r_rd1 <= mem1[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_sel <= i_front;
    end

    assign o_rd_data = r_sel ? r_rd1 : r_rd0;

endmodule
`default_nettype wire

// ===== hw/rtl/vdd_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vdd_checker
// Port-level checks on the result channel of the dilation block.
// ----------------------------------------------------------------------------
module vdd_checker
    import vdd_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_cfg_we,
    input wire logic [IDX_W-1:0]  i_cfg_index,
    input wire logic [CFG_W-1:0]  i_cfg_data,
    input wire logic              i_in_valid,
    input wire logic              o_in_ready,
    input wire logic [OP_W-1:0]   i_opcode,
    input wire logic [ADDR_W-1:0] i_voxel_address,
    input wire logic [PORT_W-1:0] i_voxel_value,
    input wire logic              o_out_valid,
    input wire logic              i_out_ready,
    input wire logic              o_result_kind,
    input wire logic [PORT_W-1:0] o_read_value,
    input wire logic              o_address_error,
    input wire logic [PORT_W-1:0] o_passes_done
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_result_kind)
            && $stable(o_read_value) && $stable(o_address_error) && $stable(o_passes_done)))
        else $error("result item changed while stalled");

    a_read_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind == KIND_READ) |-> (o_passes_done == '0))
        else $error("read item carries a pass count");

    a_run_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind == KIND_RUN)
            |-> (o_read_value == '0 && !o_address_error))
        else $error("run item carries read data");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_address_error) |-> (o_read_value == '0))
        else $error("failed read returned data");

endmodule

bind volume_distance_dilation vdd_checker u_vdd_checker (.*);
`default_nettype wire

// ===== dv/volume_distance_dilation_checker.sv =====
// ----------------------------------------------------------------------------
// volume_distance_dilation_checker
// Watches the configuration port and both item channels of the dilation
// block. It keeps its own copy of the voxel volume and the volume size. For
// each accepted read or run item it predicts the result and queues it. Each
// accepted result is compared field by field with the oldest queued prediction.
// ----------------------------------------------------------------------------
module volume_distance_dilation_checker
    import vdd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_ready,
    input  wire logic [OP_W-1:0]   i_opcode,
    input  wire logic [ADDR_W-1:0] i_voxel_address,
    input  wire logic [PORT_W-1:0] i_voxel_value,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_ready,
    input  wire logic              i_result_kind,
    input  wire logic [PORT_W-1:0] i_read_value,
    input  wire logic              i_address_error,
    input  wire logic [PORT_W-1:0] i_passes_done,
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct packed {
        logic              kind;
        logic [PORT_W-1:0] value;
        logic              error;
        logic [PORT_W-1:0] passes;
    } voxel_result_t;

    logic [PORT_W-1:0] voxels [0:262143];
    logic [CFG_W-1:0]  edge_reg [0:2];
    voxel_result_t     expected_results [$];

    function automatic int clamp_edge(input logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > 64)
            return 64;
        return int'(v);
    endfunction

    function automatic void take_neighbour(inout logic [PORT_W-1:0] best,
                                           input logic [PORT_W-1:0] nb,
                                           input int thr);
        if (int'(nb) >= thr && nb > best)
            best = nb;
    endfunction

    // Largest value M, then up to M threshold passes; stops once stable.
    function automatic logic [PORT_W-1:0] dilate_volume();
        int rs, cs, ds, ps, n, x, y, z, p, thr;
        logic [PORT_W-1:0] m, best;
        logic [PORT_W-1:0] nxt [];
        bit changed;
        rs = clamp_edge(edge_reg[0]);
        cs = clamp_edge(edge_reg[1]);
        ds = clamp_edge(edge_reg[2]);
        ps = rs * cs;
        n  = ps * ds;
        m  = 0;
        for (p = 0; p < n; p++)
            if (voxels[p] > m)
                m = voxels[p];
        nxt = new[n];
        for (thr = 0; thr < int'(m); thr++) begin
            changed = 0;
            p = 0;
            for (z = 0; z < ds; z++)
                for (y = 0; y < cs; y++)
                    for (x = 0; x < rs; x++) begin
                        best = voxels[p];
                        if (x > 0)      take_neighbour(best, voxels[p-1], thr);
                        if (x + 1 < rs) take_neighbour(best, voxels[p+1], thr);
                        if (y > 0)      take_neighbour(best, voxels[p-rs], thr);
                        if (y + 1 < cs) take_neighbour(best, voxels[p+rs], thr);
                        if (z > 0)      take_neighbour(best, voxels[p-ps], thr);
                        if (z + 1 < ds) take_neighbour(best, voxels[p+ps], thr);
                        if (best != voxels[p])
                            changed = 1;
                        nxt[p] = best;
                        p++;
                    end
            for (p = 0; p < n; p++)
                voxels[p] = nxt[p];
            if (!changed)
                break;
        end
        return m;
    endfunction

    initial begin
        for (int i = 0; i < 262144; i++)
            voxels[i] = '0;
    end

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        int total;
        voxel_result_t exp_r;
        if (!i_rst_n) begin
            edge_reg[0] = CFG_RESET;
            edge_reg[1] = CFG_RESET;
            edge_reg[2] = CFG_RESET;
        end else begin
            if (i_cfg_we && i_cfg_index <= REG_SLICE)
                edge_reg[i_cfg_index] = i_cfg_data;
            total = clamp_edge(edge_reg[0]) * clamp_edge(edge_reg[1])
                  * clamp_edge(edge_reg[2]);
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected");
                    o_fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (i_result_kind !== exp_r.kind) begin
                        $error("result_kind expected %0d got %0d", exp_r.kind, i_result_kind);
                        o_fail_count++;
                    end
                    if (i_read_value !== exp_r.value) begin
                        $error("read_value expected %0d got %0d", exp_r.value, i_read_value);
                        o_fail_count++;
                    end
                    if (i_address_error !== exp_r.error) begin
                        $error("address_error expected %0d got %0d",
                               exp_r.error, i_address_error);
                        o_fail_count++;
                    end
                    if (i_passes_done !== exp_r.passes) begin
                        $error("passes_done expected %0d got %0d",
                               exp_r.passes, i_passes_done);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                case (i_opcode)
                    OP_WRITE: begin
                        if (int'(i_voxel_address) < total)
                            voxels[i_voxel_address] = i_voxel_value;
                    end
                    OP_RUN: begin
                        exp_r = '{kind: KIND_RUN, value: '0, error: 1'b0,
                                  passes: dilate_volume()};
                        expected_results.push_back(exp_r);
                    end
                    OP_READ: begin
                        if (int'(i_voxel_address) < total)
                            exp_r = '{kind: KIND_READ, value: voxels[i_voxel_address],
                                      error: 1'b0, passes: '0};
                        else
                            exp_r = '{kind: KIND_READ, value: '0, error: 1'b1,
                                      passes: '0};
                        expected_results.push_back(exp_r);
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the volume distance dilation block. Runs through a series of
// volume sizes, from a single voxel up to the full volume, with writes,
// reads in and out of range, dilation runs over fully written volumes and
// unused opcodes, under varying sender idling and receiver stalls. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import vdd_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              i_cfg_we = 0;
    logic [IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_W-1:0]  i_cfg_data = '0;
    logic              i_in_valid = 0;
    logic [OP_W-1:0]   i_opcode = '0;
    logic [ADDR_W-1:0] i_voxel_address = '0;
    logic [PORT_W-1:0] i_voxel_value = '0;
    logic              i_out_ready = 0;
    logic              o_in_ready, o_out_valid, o_result_kind, o_address_error;
    logic [PORT_W-1:0] o_read_value, o_passes_done;
    int                fail_count, pending;

    int idle_pct  = 0;
    int stall_pct = 0;
    int rs = 64, cs = 64, ds = 64, total = 262144;
    bit stored [0:262143];
    int stored_list [$];

    volume_distance_dilation DUT (.*);

    volume_distance_dilation_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_opcode(i_opcode),
        .i_voxel_address(i_voxel_address), .i_voxel_value(i_voxel_value),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_result_kind(o_result_kind), .i_read_value(o_read_value),
        .i_address_error(o_address_error), .i_passes_done(o_passes_done),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(99) >= stall_pct);

    initial begin
        #100_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int clamp_edge(input int v);
        return (v == 0) ? 1 : (v > 64) ? 64 : v;
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input int addr,
                             input logic [PORT_W-1:0] val);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1;
        i_opcode        <= op;
        i_voxel_address <= addr[ADDR_W-1:0];
        i_voxel_value   <= val;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        if (op == OP_WRITE && addr < total && !stored[addr]) begin
            stored[addr] = 1;
            stored_list.push_back(addr);
        end
        @(negedge i_clk);
    endtask

    // Only while idle: drain results, allow for trailing work, then write.
    task automatic set_volume(input int row, input int col, input int slc);
        i_in_valid <= 0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= REG_ROW;
        i_cfg_data <= row[CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_index <= REG_COLUMN;
        i_cfg_data <= col[CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_index <= REG_SLICE;
        i_cfg_data <= slc[CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 0;
        @(negedge i_clk);
        rs = clamp_edge(row);
        cs = clamp_edge(col);
        ds = clamp_edge(slc);
        total = rs * cs * ds;
    endtask

    function automatic int pick_read_addr();
        int a;
        if (total < 262144 && $urandom_range(99) < 15)
            return $urandom_range(262143, total);
        a = $urandom_range(total - 1);
        if (!stored[a])
            a = stored_list[$urandom_range(stored_list.size() - 1)];
        return a;
    endfunction

    function automatic logic [PORT_W-1:0] pick_value();
        return ($urandom_range(1)) ? PORT_W'($urandom_range(15))
                                   : PORT_W'($urandom_range(65535));
    endfunction

    initial begin
        int phase_cfg [12][3] = '{
            '{1, 1, 1}, '{0, 127, 1}, '{2, 3, 4}, '{4, 4, 4}, '{127, 127, 127},
            '{3, 1, 5}, '{16, 2, 1}, '{0, 0, 0}, '{5, 2, 3}, '{1, 1, 40},
            '{4, 3, 2}, '{3, 3, 3}};
        int r, addr;
        bit can_run;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // full volume after reset: field extremes, unused opcode
        send_item(OP_WRITE, 0, 16'hFFFF);
        send_item(OP_WRITE, 262143, 16'h0000);
        send_item(OP_WRITE, 18'h2AAAA, 16'hAAAA);
        send_item(OP_WRITE, 18'h15555, 16'h5555);
        send_item(OP_READ, 0, 16'h0);
        send_item(OP_READ, 262143, 16'hFFFF);
        send_item(OP_READ, 18'h2AAAA, 16'h0);
        send_item(OP_READ, 18'h15555, 16'h0);
        send_item(OP_UNUSED, 18'h3FFFF, 16'hFFFF);
        send_item(OP_WRITE, 0, 16'h0001);
        send_item(OP_READ, 0, 16'h0);

        for (int ph = 0; ph < 12; ph++) begin
            set_volume(phase_cfg[ph][0], phase_cfg[ph][1], phase_cfg[ph][2]);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 49; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 49; end
                default: begin idle_pct = 36; stall_pct = 36; end
            endcase
            can_run = (total <= 64);
            if (can_run) begin
                // fill the whole volume and run; single voxel: empty volume, then a lone peak
                for (int a = 0; a < total; a++)
                    send_item(OP_WRITE, a, (ph == 0) ? 16'h0 : pick_value());
                send_item(OP_RUN, 0, 16'h0);
                if (ph == 0) begin
                    send_item(OP_WRITE, 0, 16'hFFFF);
                    send_item(OP_RUN, 0, 16'h0);
                    send_item(OP_READ, 0, 16'h0);
                    send_item(OP_READ, 1, 16'h0);
                    send_item(OP_READ, 262143, 16'h0);
                end
            end
            for (int k = 0; k < 92; k++) begin
                r = $urandom_range(99);
                if (r < 45) begin
                    addr = ($urandom_range(99) < 85) ? $urandom_range(total - 1)
                                                     : $urandom_range(262143);
                    send_item(OP_WRITE, addr, pick_value());
                end else if (r < 85 || !can_run) begin
                    if (r >= 93)
                        send_item(OP_UNUSED, $urandom_range(262143),
                                  PORT_W'($urandom_range(65535)));
                    else
                        send_item(OP_READ, pick_read_addr(),
                                  PORT_W'($urandom_range(65535)));
                end else if (r < 93) begin
                    send_item(OP_RUN, $urandom_range(262143),
                              PORT_W'($urandom_range(65535)));
                end else begin
                    send_item(OP_UNUSED, $urandom_range(262143),
                              PORT_W'($urandom_range(65535)));
                end
            end
        end

        i_in_valid <= 0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
